/* rtl/h2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package h2d_pkg;

	// Value and digit sizing
	localparam int VALUE_BITS     = 32;
	localparam int MAX_DEC_DIGITS = 10;
	// Decimal digits needed for VALUE_BITS bits: ceil(VALUE_BITS * log10(2))
	localparam int BCD_CELLS      = (VALUE_BITS * 30103 + 99999) / 100000;
	localparam int DIG_IDX_W      = $clog2(BCD_CELLS);
	localparam int DIG_CNT_W      = $clog2(BCD_CELLS + 1);
	localparam int BIT_CNT_W      = $clog2(VALUE_BITS);
	localparam int LIMIT_W        = 4;

	// Character codes
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_LOW_A  = 8'd97;
	localparam logic [7:0] CHAR_LOW_F  = 8'd102;
	localparam logic [7:0] LETTER_BIAS = 8'd87;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

	typedef struct packed {
		logic [7:0] hex_char;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic [5:0] dec_char;
		logic       fits;
		logic       last_digit;
	} dig_item_t;

	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctl_t;

	typedef logic [BCD_CELLS-1:0][3:0] bcd_row_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

/* rtl/h2d_bcd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module h2d_bcd_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       clear,
	input  wire logic       shift,
	input  wire logic       bit_in,
	output logic            carry_out,
	output logic [3:0]      digit
);
	import h2d_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add-3 correction ahead of the shift
	always_comb begin
		adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= 4'd0;
		end else if (clear) begin
			digit_q <= 4'd0;
		end else if (shift) begin
			digit_q <= {adj[2:0], bit_in};
		end
	end

endmodule

`default_nettype wire

/* rtl/h2d_bcd_chain.sv */
`timescale 1ns / 1ps
`default_nettype none

module h2d_bcd_chain (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire h2d_pkg::chain_ctl_t             ctl,
	input  wire logic [h2d_pkg::VALUE_BITS-1:0]  value,
	output h2d_pkg::bcd_row_t                    digits
);
	import h2d_pkg::*;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_CELLS:0]    carry;

	// binary shift register feeds the row MSB first
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= value;
		end else if (ctl.shift) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign carry[0] = bin_q[VALUE_BITS-1];

	// row of BCD digit cells, least significant at index 0
	for (genvar i = 0; i < BCD_CELLS; i++) begin : g_cell
		h2d_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear     (ctl.load),
			.shift     (ctl.shift),
			.bit_in    (carry[i]),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

endmodule

`default_nettype wire

/* rtl/hex_to_decimal_ascii_converter_top.sv */
// Hex characters are taken one per cycle while accumulating.
// After the last character: double-dabble of the VALUE_BITS (32) bit value through
// the BCD cell row, a sizing state, then one result item per cycle while the
// receiver does not stall (1 to 10 items).
// Reset (arst_n low, async) clears the accumulator, sets digit_limit to 10.
`timescale 1ns / 1ps
`default_nettype none

module hex_to_decimal_ascii_converter_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire h2d_pkg::char_item_t           char_item,
	output logic                               dig_valid,
	input  wire logic                          dig_stall,
	output h2d_pkg::dig_item_t                 dig_item,
	input  wire logic                          cfg_we,
	input  wire logic [h2d_pkg::LIMIT_W-1:0]   cfg_wdata
);
	import h2d_pkg::*;

	state_t                  state_q, state_nxt;
	logic [VALUE_BITS-1:0]   acc_q, acc_nxt, weight;
	logic [LIMIT_W-1:0]      limit_q;
	logic [BIT_CNT_W-1:0]    bit_cnt_q;
	logic [DIG_IDX_W-1:0]    idx_q, top_idx;
	logic                    fits_q, fits_calc;
	logic [DIG_CNT_W-1:0]    dig_cnt;
	logic                    char_take, emit_ok, emit_last;
	chain_ctl_t              chain_ctl;
	bcd_row_t                digits;
	logic                    dig_valid_q;
	dig_item_t               dig_item_q, emit_item;

	// character weight and accumulate
	always_comb begin
		if (char_item.hex_char >= CHAR_LOW_A && char_item.hex_char <= CHAR_LOW_F) begin
			weight = VALUE_BITS'(char_item.hex_char) - VALUE_BITS'(LETTER_BIAS);
		end else begin
			weight = VALUE_BITS'(char_item.hex_char) - VALUE_BITS'(CHAR_ZERO);
		end
		acc_nxt = {acc_q[VALUE_BITS-5:0], 4'b0000} + weight;
	end

	// digit count from the highest nonzero cell
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < BCD_CELLS; i++) begin
			if (digits[i] != 4'd0) begin
				top_idx = DIG_IDX_W'(i);
			end
		end
		dig_cnt   = DIG_CNT_W'(top_idx) + DIG_CNT_W'(1);
		fits_calc = (32'(dig_cnt) <= 32'(limit_q)) && (32'(dig_cnt) <= 32'(MAX_DEC_DIGITS));
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (char_take && char_item.last_char) begin
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
					state_nxt = ST_SIZE;
				end
			end
			ST_SIZE: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok && emit_last) begin
					state_nxt = ST_ACCUM;
				end
			end
			default: state_nxt = ST_ACCUM;
		endcase
	end

	// control outputs
	always_comb begin
		char_stall      = (state_q != ST_ACCUM);
		char_take       = char_valid && !char_stall;
		chain_ctl.load  = char_take && char_item.last_char;
		chain_ctl.shift = (state_q == ST_CONV);
		emit_ok         = (state_q == ST_EMIT) && (!dig_valid_q || !dig_stall);
		emit_last       = !fits_q || (idx_q == '0);
		if (fits_q) begin
			emit_item.dec_char = CHAR_ZERO[5:0] + {2'b00, digits[idx_q]};
			emit_item.fits     = 1'b1;
		end else begin
			emit_item.dec_char = 6'd0;
			emit_item.fits     = 1'b0;
		end
		emit_item.last_digit = emit_last;
	end

	// state, accumulator and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACCUM;
			acc_q     <= '0;
			limit_q   <= LIMIT_RESET;
			bit_cnt_q <= '0;
			idx_q     <= '0;
			fits_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (char_take) begin
				acc_q <= char_item.last_char ? '0 : acc_nxt;
			end
			if (chain_ctl.load) begin
				bit_cnt_q <= '0;
			end else if (chain_ctl.shift) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end
			if (state_q == ST_SIZE) begin
				idx_q  <= top_idx;
				fits_q <= fits_calc;
			end else if (emit_ok) begin
				idx_q <= idx_q - DIG_IDX_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
		end else if (emit_ok) begin
			dig_valid_q <= 1'b1;
		end else if (!dig_stall) begin
			dig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ok) begin
			dig_item_q <= emit_item;
		end
	end

	assign dig_valid = dig_valid_q;
	assign dig_item  = dig_item_q;

	h2d_bcd_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.value  (acc_nxt),
		.digits (digits)
	);

endmodule

`default_nettype wire

/* tb/sv/hex_to_decimal_ascii_converter_top_tb.sv */
`timescale 1ns / 1ps

module hex_to_decimal_ascii_converter_top_tb;
	import h2d_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	// margin covering conversion, sizing and up to 10 digits
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_CHARS   = 45;
	localparam int DIGIT_BUF     = 20;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	char_item_t char_item  = '0;
	logic       dig_valid;
	logic       dig_stall  = 1'b0;
	dig_item_t  dig_item;
	logic       cfg_we     = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	// characters waiting to be sent, digits waiting to come back
	char_item_t pending_chars[$];
	dig_item_t  expected_digits[$];

	// predictor state
	logic [VALUE_BITS-1:0] running_value;
	int digit_limit_model;

	int error_count      = 0;
	int cycle_count      = 0;
	int chars_accepted   = 0;
	int strings_accepted = 0;
	int digits_checked   = 0;
	int overflows_seen   = 0;
	int zeros_seen       = 0;

	// sender pacing
	int burst_left = 8;
	int gap_left   = 0;

	// receiver stall pattern
	int stall_mode = 0;
	int mode_left  = 100;

	hex_to_decimal_ascii_converter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig_item   (dig_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		if (error_count < 50)
			$display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	// Fold one character into the value; on the last one, queue the digits it yields
	task automatic predict_conversion(input char_item_t ci);
		logic [VALUE_BITS-1:0] weight;
		logic [VALUE_BITS-1:0] v;
		logic [3:0] digits [DIGIT_BUF];
		dig_item_t d;
		int n;
		if (ci.hex_char >= CHAR_LOW_A && ci.hex_char <= CHAR_LOW_F)
			weight = VALUE_BITS'(ci.hex_char) - VALUE_BITS'(LETTER_BIAS);
		else
			weight = VALUE_BITS'(ci.hex_char) - VALUE_BITS'(CHAR_ZERO);
		running_value = (running_value << 4) + weight;
		if (!ci.last_char)
			return;
		v = running_value;
		running_value = '0;
		strings_accepted++;
		if (v == 0)
			zeros_seen++;
		n = 0;
		do begin
			digits[n] = 4'(v % 10);
			v = v / 10;
			n++;
		end while (v != 0 && n < DIGIT_BUF);
		// too many digits: a single not-fits item
		if (n > digit_limit_model || n > MAX_DEC_DIGITS) begin
			d.dec_char   = '0;
			d.fits       = 1'b0;
			d.last_digit = 1'b1;
			expected_digits.push_back(d);
			return;
		end
		for (int k = 0; k < n; k++) begin
			d.dec_char   = 6'(CHAR_ZERO + digits[n - 1 - k]);
			d.fits       = 1'b1;
			d.last_digit = (k == n - 1);
			expected_digits.push_back(d);
		end
	endtask

	// Driver: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_item  <= '0;
		end else begin
			if (char_valid && !char_stall) begin
				predict_conversion(char_item);
				chars_accepted++;
			end
			if (!char_valid || !char_stall) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					char_valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					char_item  <= pending_chars.pop_front();
					char_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: free-flowing, random, or periodic, switching now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: dig_stall <= 1'b0;
				1: dig_stall <= ($urandom_range(0, 2) == 0);
				default: dig_stall <= ((cycle_count % 8) < 5);
			endcase
		end
	end

	// Monitor: compare each accepted digit with the oldest expectation
	always @(posedge clk) begin
		dig_item_t want;
		if (arst_n && dig_valid && !dig_stall) begin
			if (expected_digits.size() == 0) begin
				flag_mismatch($sformatf("unexpected digit item %p", dig_item));
			end else begin
				want = expected_digits.pop_front();
				digits_checked++;
				if (!want.fits)
					overflows_seen++;
				if (dig_item.dec_char !== want.dec_char)
					flag_mismatch($sformatf("dec_char %0d, want %0d",
						dig_item.dec_char, want.dec_char));
				if (dig_item.fits !== want.fits)
					flag_mismatch($sformatf("fits %b, want %b", dig_item.fits, want.fits));
				if (dig_item.last_digit !== want.last_digit)
					flag_mismatch($sformatf("last_digit %b, want %b",
						dig_item.last_digit, want.last_digit));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digits outstanding",
				cycle_count, expected_digits.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic queue_char(input logic [7:0] c, input logic last);
		char_item_t it;
		it.hex_char  = c;
		it.last_char = last;
		pending_chars.push_back(it);
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1);
	endtask

	// Mostly well-formed hex strings, some wrapping, some all zeros, some with stray characters
	task automatic queue_random_string(output int len);
		int kind;
		int r;
		logic [7:0] c;
		kind = $urandom_range(0, 9);
		if (kind < 7)
			len = $urandom_range(1, 8);
		else if (kind < 9)
			len = $urandom_range(9, 12);
		else
			len = $urandom_range(1, 3);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 19);
			if (kind == 9)
				c = CHAR_ZERO;
			else if (r == 0)
				c = 8'($urandom_range(0, 255));
			else if (r < 11)
				c = CHAR_ZERO + 8'($urandom_range(0, 9));
			else
				c = CHAR_LOW_A + 8'($urandom_range(0, 5));
			queue_char(c, i == len - 1);
		end
	endtask

	task automatic wait_idle();
		while (pending_chars.size() != 0 || char_valid || expected_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_digit_limit(input logic [LIMIT_W-1:0] lim);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		digit_limit_model = int'(lim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stimulus
	initial begin
		int limits [RANDOM_PHASES];
		int phase_chars;
		int len;
		running_value     = '0;
		digit_limit_model = int'(LIMIT_RESET);
		limits = '{0, 15, 3, 10, 1, 11, 7, 5};
		limits[RANDOM_PHASES - 1] = $urandom_range(0, 15);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero, extremes, letters, stray and out-of-range codes
		queue_string("0");
		queue_string("ffffffff");
		queue_string("80000000");
		queue_string("9");
		queue_string("a");
		queue_string("F");
		queue_char(8'h00, 1'b1);
		queue_char(8'hff, 1'b1);
		queue_char(8'h60, 1'b0);
		queue_char(CHAR_LOW_F + 8'd1, 1'b1);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_digit_limit(LIMIT_W'(limits[p]));
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS) begin
				queue_random_string(len);
				phase_chars += len;
			end
			wait_idle();
		end

		$display("%0d chars in %0d strings; %0d digit items checked, %0d not-fits, %0d zeros",
			chars_accepted, strings_accepted, digits_checked, overflows_seen, zeros_seen);
		$display("digit limit swept through 0, 1, 3, 7, 10, 11, 15, one random value %0d %s",
			limits[RANDOM_PHASES - 1], "and the reset default");
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
rtl/h2d_pkg.sv
rtl/h2d_bcd_cell.sv
rtl/h2d_bcd_chain.sv
rtl/hex_to_decimal_ascii_converter_top.sv
tb/sv/hex_to_decimal_ascii_converter_top_tb.sv
